// ===== hw/rtl/maf_pkg.sv =====
// Shared constants for the moving average filter.
// No dependencies; used by every module of the block.
package maf_pkg;

    // Default parameter values
    localparam int WINDOW_MAX_DEF   = 64;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // Window length register
    localparam int              LEN_W      = 7;
    localparam logic [LEN_W-1:0] WLEN_RESET = 7'd8;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

endpackage

// ===== hw/rtl/maf_front.sv =====
// Front end: accepts samples, keeps the sample ring and the running sum.
// Depends on maf_pkg.
module maf_front #(
    parameter int WINDOW_MAX   = maf_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = maf_pkg::SAMPLE_WIDTH_DEF,
    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
    localparam int SUM_W = SAMPLE_WIDTH + IDX_W + 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_clear,
    input  logic [maf_pkg::LEN_W-1:0]      i_len,
    input  logic                           i_valid,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    output logic                           o_busy,
    output logic                           o_push,
    output logic signed [SUM_W-1:0]        o_sum
);

    // Sample ring
    logic signed [SAMPLE_WIDTH-1:0] r_ring [WINDOW_MAX];
    logic signed [SAMPLE_WIDTH-1:0] r_rd;
    logic signed [SAMPLE_WIDTH-1:0] r_x;

    logic                    r_busy, r_full, r_rd_ok;
    logic [IDX_W-1:0]        r_wi, n_wi;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic [IDX_W:0]          w_wi_inc;
    logic                    w_wrap;
    logic signed [SUM_W-1:0] w_old;

    // Ring read on accept, write on the following cycle
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_rd <= r_ring[r_wi];
            r_x  <= i_sample;
        end
        if (r_busy) begin
            r_ring[r_wi] <= r_x;
        end
    end

    // Slot being replaced counts as zero until the ring has wrapped once
    assign w_old    = r_rd_ok ? SUM_W'(r_rd) : '0;
    assign n_sum    = r_sum - w_old + SUM_W'(r_x);
    assign w_wi_inc = {1'b0, r_wi} + 1'b1;
    assign w_wrap   = 32'(w_wi_inc) >= 32'(i_len);
    assign n_wi     = w_wrap ? '0 : w_wi_inc[IDX_W-1:0];

    // Control and running sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_busy  <= 1'b0;
            r_full  <= 1'b0;
            r_rd_ok <= 1'b0;
            r_wi    <= '0;
            r_sum   <= '0;
        end else begin
            if (i_valid) begin
                r_busy  <= 1'b1;
                r_rd_ok <= r_full;
            end else if (r_busy) begin
                r_busy <= 1'b0;
                r_sum  <= n_sum;
                r_wi   <= n_wi;
                if (w_wrap) begin
                    r_full <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_push = r_busy;
    assign o_sum  = n_sum;

endmodule

// ===== hw/rtl/maf_queue.sv =====
// Short queue of running sums between front end and divider.
// Depends on maf_pkg.
module maf_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = maf_pkg::QUEUE_DEPTH,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push, w_pop;

    assign w_push = i_push && !o_full;
    assign w_pop  = i_pop && !o_empty;

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (32'(r_wp) == DEPTH - 1) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (32'(r_rp) == DEPTH - 1) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_full  = 32'(r_cnt) == DEPTH;
    assign o_empty = r_cnt == '0;
    assign o_data  = r_mem[r_rp];

endmodule

// ===== hw/rtl/maf_div.sv =====
// Back end: divides each running sum by the window length, one quotient
// bit per cycle, truncating toward zero. Holds the result register.
// Depends on maf_pkg.
module maf_div #(
    parameter int SAMPLE_WIDTH = maf_pkg::SAMPLE_WIDTH_DEF,
    parameter int SUM_W        = 23,
    localparam int CNT_W = $clog2(SUM_W + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic signed [SUM_W-1:0]        i_sum,
    input  logic [maf_pkg::LEN_W-1:0]      i_len,
    output logic                           o_take,
    output logic                           o_empty,
    input  logic                           i_pop,
    output logic signed [SAMPLE_WIDTH-1:0] o_mean
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                     r_state;
    logic [CNT_W-1:0]               r_cnt;
    logic [SUM_W-1:0]               r_q;
    logic [maf_pkg::LEN_W-1:0]      r_rem;
    logic                           r_neg;
    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out;

    logic [maf_pkg::LEN_W:0]   w_trial;
    logic [SUM_W-1:0]          w_res;
    logic                      w_load_out;

    // One restoring step: shift in next dividend bit, try subtract
    assign w_trial = {r_rem, r_q[SUM_W-1]} - {1'b0, i_len};
    assign w_res   = r_neg ? (~r_q + 1'b1) : r_q;

    assign o_take     = (r_state == ST_IDLE) && i_valid;
    assign w_load_out = (r_state == ST_DONE) && (!r_out_valid || i_pop);

    // Sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_state <= ST_RUN;
                        r_cnt   <= '0;
                    end
                end
                ST_RUN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (32'(r_cnt) == SUM_W - 1) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_load_out) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Magnitude and quotient bits
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_neg <= i_sum[SUM_W-1];
            r_q   <= i_sum[SUM_W-1] ? SUM_W'(-i_sum) : i_sum;
            r_rem <= '0;
        end else if (r_state == ST_RUN) begin
            if (!w_trial[maf_pkg::LEN_W]) begin
                r_rem <= w_trial[maf_pkg::LEN_W-1:0];
                r_q   <= {r_q[SUM_W-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[maf_pkg::LEN_W-2:0], r_q[SUM_W-1]};
                r_q   <= {r_q[SUM_W-2:0], 1'b0};
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out <= w_res[SAMPLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_empty = !r_out_valid;
    assign o_mean  = r_out;

endmodule

// ===== hw/rtl/moving_average_filter.sv =====
// Top level of the moving average filter.
// Depends on maf_pkg, maf_front, maf_queue and maf_div.

// Boxcar moving average over signed fixed-point samples. Each sample
// pushed gives one result: the mean of that sample and the previous
// window_len-1 samples, truncated toward zero; samples older than reset
// or the last window_len write count as zero. window_len 0 acts as 1 and
// values above WINDOW_MAX act as WINDOW_MAX. Writing window_len clears
// the history, so write it only while the block is idle. The front end
// takes no new sample until it is through with the last one (registered
// ring read, then ring write and sum update); the back end divides one
// sum at a time, bit-serially, with sums of SUM_W = SAMPLE_WIDTH +
// clog2(WINDOW_MAX) + 1 bits, and so sets the sustained rate. A two-entry
// queue between the ends and the result register let each side stall
// independently. A result passes through the queue, the divider and
// the result register before it can be popped.
module moving_average_filter #(
    parameter int WINDOW_MAX   = maf_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = maf_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [maf_pkg::LEN_W-1:0]      i_cfg_wr_data,
    input  logic                           push,
    output logic                           full,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    output logic                           empty,
    input  logic                           pop,
    output logic signed [SAMPLE_WIDTH-1:0] o_mean
);

    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int SUM_W = SAMPLE_WIDTH + IDX_W + 1;

    logic [maf_pkg::LEN_W-1:0] r_wlen;
    logic [maf_pkg::LEN_W-1:0] w_len;
    logic                      w_accept;
    logic                      w_front_busy;
    logic                      w_q_push, w_q_full, w_q_empty, w_q_pop;
    logic signed [SUM_W-1:0]   w_front_sum;
    logic [SUM_W-1:0]          w_q_data;

    // Window length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen <= maf_pkg::WLEN_RESET;
        end else if (i_cfg_wr_en) begin
            r_wlen <= i_cfg_wr_data;
        end
    end

    // Effective window length
    always_comb begin
        if (r_wlen == '0) begin
            w_len = maf_pkg::LEN_W'(1);
        end else if (32'(r_wlen) > WINDOW_MAX) begin
            w_len = maf_pkg::LEN_W'(WINDOW_MAX);
        end else begin
            w_len = r_wlen;
        end
    end

    assign full     = w_front_busy || w_q_full;
    assign w_accept = push && !full;

    maf_front #(
        .WINDOW_MAX   (WINDOW_MAX),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (i_cfg_wr_en),
        .i_len    (w_len),
        .i_valid  (w_accept),
        .i_sample (i_sample),
        .o_busy   (w_front_busy),
        .o_push   (w_q_push),
        .o_sum    (w_front_sum)
    );

    maf_queue #(
        .WIDTH (SUM_W),
        .DEPTH (maf_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_front_sum),
        .i_pop   (w_q_pop),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_data  (w_q_data)
    );

    maf_div #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .SUM_W        (SUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (!w_q_empty),
        .i_sum   ($signed(w_q_data)),
        .i_len   (w_len),
        .o_take  (w_q_pop),
        .o_empty (empty),
        .i_pop   (pop),
        .o_mean  (o_mean)
    );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for moving_average_filter: directed table, then random phases.
// Depends on maf_pkg and moving_average_filter; predicts each mean with its own boxcar model.
`timescale 1ns / 1ps

module testbench;

    localparam int WIN_MAX     = 64;
    localparam int DRAIN_CYC   = 40;          // covers push-to-result latency
    localparam int N_PHASES    = 12;
    localparam int PHASE_ITEMS = 165;
    localparam int N_ROWS      = 25;
    localparam longint TIMEOUT_NS = 64'd30_000_000;

    typedef enum logic {ROW_SAMPLE, ROW_LEN} t_row_kind;

    typedef struct packed {
        t_row_kind                 kind;
        logic [maf_pkg::LEN_W-1:0] len;
        logic signed [15:0]        sample;
        logic                      has_mean;
        logic signed [15:0]        mean;
    } t_stim_row;

    // Directed table: extremes, truncation toward zero, zero and oversized window
    localparam t_stim_row DIR_ROWS [N_ROWS] = '{
        '{ROW_SAMPLE, 7'd0,   16'sh7FFF, 1'b1, 16'sd4095},
        '{ROW_SAMPLE, 7'd0,   16'sh7FFF, 1'b1, 16'sd8191},
        '{ROW_SAMPLE, 7'd0,   16'sh8000, 1'b1, 16'sd4095},
        '{ROW_SAMPLE, 7'd0,   16'sh0001, 1'b0, 16'sd0},
        '{ROW_LEN,    7'd1,   16'sh0000, 1'b0, 16'sd0},
        '{ROW_SAMPLE, 7'd0,   16'sh8000, 1'b1, 16'sh8000},
        '{ROW_SAMPLE, 7'd0,   16'sh7FFF, 1'b1, 16'sh7FFF},
        '{ROW_SAMPLE, 7'd0,   16'sh5555, 1'b1, 16'sh5555},
        '{ROW_SAMPLE, 7'd0,   16'shAAAA, 1'b1, 16'shAAAA},
        '{ROW_LEN,    7'd0,   16'sh0000, 1'b0, 16'sd0},
        '{ROW_SAMPLE, 7'd0,   16'shFFFF, 1'b1, 16'shFFFF},
        '{ROW_SAMPLE, 7'd0,   16'sh0001, 1'b1, 16'sh0001},
        '{ROW_LEN,    7'd2,   16'sh0000, 1'b0, 16'sd0},
        '{ROW_SAMPLE, 7'd0,   -16'sd3,   1'b1, -16'sd1},
        '{ROW_SAMPLE, 7'd0,   16'sh0000, 1'b1, -16'sd1},
        '{ROW_SAMPLE, 7'd0,   16'sh0000, 1'b1, 16'sd0},
        '{ROW_LEN,    7'd127, 16'sh0000, 1'b0, 16'sd0},
        '{ROW_SAMPLE, 7'd0,   16'sh8000, 1'b1, -16'sd512},
        '{ROW_SAMPLE, 7'd0,   16'sh8000, 1'b1, -16'sd1024},
        '{ROW_SAMPLE, 7'd0,   16'sh0001, 1'b1, -16'sd1023},
        '{ROW_LEN,    7'd65,  16'sh0000, 1'b0, 16'sd0},
        '{ROW_SAMPLE, 7'd0,   16'sh7FFF, 1'b1, 16'sd511},
        '{ROW_LEN,    7'd64,  16'sh0000, 1'b0, 16'sd0},
        '{ROW_SAMPLE, 7'd0,   16'shFFFF, 1'b1, 16'sd0},
        '{ROW_SAMPLE, 7'd0,   16'sh5555, 1'b0, 16'sd0}
    };

    // DUT ports; the driven inputs are known from time zero
    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      i_cfg_wr_en   = 1'b0;
    logic [maf_pkg::LEN_W-1:0] i_cfg_wr_data = '0;
    logic                      push          = 1'b0;
    logic                      full;
    logic signed [15:0]        i_sample      = '0;
    logic                      empty;
    logic                      pop           = 1'b0;
    logic signed [15:0]        o_mean;

    // Boxcar predictor state
    logic signed [15:0]        ring [WIN_MAX];
    int                        ring_sum;
    int                        ring_slot;
    logic [maf_pkg::LEN_W-1:0] len_reg;

    logic signed [15:0] mean_q [$];
    int                 errors   = 0;
    int                 send_pct = 0;
    int                 recv_pct = 0;

    moving_average_filter u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .push         (push),
        .full         (full),
        .i_sample     (i_sample),
        .empty        (empty),
        .pop          (pop),
        .o_mean       (o_mean)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void clear_ring();
        for (int i = 0; i < WIN_MAX; i++) ring[i] = '0;
        ring_sum  = 0;
        ring_slot = 0;
    endfunction

    // Advance the predictor by one sample, return the truncated mean
    function automatic logic signed [15:0] boxcar_step(input logic signed [15:0] x);
        int span;
        int q;
        span = (len_reg == 0) ? 1 : (len_reg > WIN_MAX) ? WIN_MAX : int'(len_reg);
        if (ring_slot >= span) ring_slot = 0;
        ring_sum = ring_sum - ring[ring_slot] + x;
        ring[ring_slot] = x;
        ring_slot++;
        if (ring_slot >= span) ring_slot = 0;
        q = ring_sum / span;
        return q[15:0];
    endfunction

    function automatic logic signed [15:0] pick_sample(input int bias);
        int r;
        r = $urandom_range(0, 99);
        if (bias == 1 && r < 80) return 16'sh8000;
        if (bias == 2 && r < 80) return 16'sh7FFF;
        if (r < 10) return 16'sh8000;
        if (r < 20) return 16'sh7FFF;
        if (r < 30) return 16'($signed($urandom_range(0, 15)) - 8);
        return 16'($urandom);
    endfunction

    // One sample transaction; expectation is queued when it is accepted
    task automatic send_sample(input logic signed [15:0] x, input logic has_mean,
                               input logic signed [15:0] typed_mean);
        logic signed [15:0] predicted;
        while ($urandom_range(0, 99) < send_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push     <= 1'b1;
        i_sample <= x;
        do @(posedge i_clk); while (full);
        predicted = boxcar_step(x);
        mean_q.push_back(has_mean ? typed_mean : predicted);
    endtask

    // Stop sending and let every pending mean come out
    task automatic drain();
        push <= 1'b0;
        while (mean_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_len(input logic [maf_pkg::LEN_W-1:0] v);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        len_reg = v;
        clear_ring();
    endtask

    // Result side: check each popped mean, then pick the next pop
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (mean_q.size() == 0) begin
                if (errors < 10) $display("unexpected result: mean %0d", o_mean);
                errors++;
            end else begin
                if (o_mean !== mean_q[0]) begin
                    if (errors < 10)
                        $display("mean mismatch: expected %0d, got %0d", mean_q[0], o_mean);
                    errors++;
                end
                void'(mean_q.pop_front());
            end
        end
        pop <= i_rst_n && ($urandom_range(0, 99) >= recv_pct);
    end

    // Hard stop if the block hangs
    initial begin
        #(TIMEOUT_NS);
        $display("testbench NOT OK");
        $finish;
    end

    initial begin
        int phase_len [N_PHASES] = '{64, 1, 0, 127, 65, 8, 2, 63, -1, -1, 64, 3};
        len_reg = maf_pkg::WLEN_RESET;
        clear_ring();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        for (int r = 0; r < N_ROWS; r++) begin
            if (DIR_ROWS[r].kind == ROW_LEN)
                write_len(DIR_ROWS[r].len);
            else
                send_sample(DIR_ROWS[r].sample, DIR_ROWS[r].has_mean, DIR_ROWS[r].mean);
        end

        // Random phases: new window each time, idling mode rotates
        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_len(phase_len[ph] < 0 ? maf_pkg::LEN_W'($urandom_range(0, 127))
                                        : maf_pkg::LEN_W'(phase_len[ph]));
            case (ph % 4)
                0: begin send_pct = 0;  recv_pct = 0;  end
                1: begin send_pct = 53; recv_pct = 0;  end
                2: begin send_pct = 0;  recv_pct = 53; end
                default: begin send_pct = 19; recv_pct = 19; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_sample(pick_sample(ph % 3), 1'b0, 16'sd0);
        end

        drain();
        if (errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/maf_pkg.sv
hw/rtl/maf_front.sv
hw/rtl/maf_queue.sv
hw/rtl/maf_div.sv
hw/rtl/moving_average_filter.sv
tb/testbench.sv
